/* hw/rtl/aadr_pkg.sv */
// ----------------------------------------------------------------------------
// aadr_pkg: shared types and constants of the divider resistance block
// Register codes, field widths, reset values and the interface structs.
// ----------------------------------------------------------------------------
package aadr_pkg;

   localparam int AADR_MAX_SAMPLES = 64;
   localparam int FULL_CODE        = 1023;

   localparam int SAMPLE_W    = 10;
   localparam int AVG_W       = 16;
   localparam int MV_W        = 13;
   localparam int RES_W       = 32;
   localparam int KNOWN_W     = 20;
   localparam int LEN_W       = 7;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PULL_UP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_MV     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOWN_OHMS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES    = 2'd3;

   localparam logic [MV_W-1:0]    RST_REF_MV     = 13'd3300;
   localparam logic [KNOWN_W-1:0] RST_KNOWN_OHMS = 20'd10000;
   localparam logic [LEN_W-1:0]   RST_SAMPLES    = 7'd50;

   typedef struct packed {
      logic               pull_up_mode;
      logic [MV_W-1:0]    ref_millivolts;
      logic [KNOWN_W-1:0] known_ohms;
      logic [LEN_W-1:0]   samples_per_reading;
   } aadr_cfg_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } aadr_back_status_type;

endpackage

/* hw/rtl/aadr_div.sv */
// ----------------------------------------------------------------------------
// aadr_div: restoring divider, one quotient bit per cycle
// Takes dividend and divisor on start, raises done for one cycle with the
// quotient once all NUM_W quotient bits are formed. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module aadr_div
   import aadr_pkg::*;
#(
   parameter int NUM_W = 36,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  dvs_ff, dvs_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W+1:0]  trial;

   assign trial = {1'b0, rem_ff, quo_ff[NUM_W-1]} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // take the trial difference as the partial remainder unless the trial subtract borrowed
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
         end else begin
            rem_in = {rem_ff[DEN_W-2:0], quo_ff[NUM_W-1]};
         end
         quo_in  = {quo_ff[NUM_W-2:0], ~trial[DEN_W+1]};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/aadr_front.sv */
// ----------------------------------------------------------------------------
// aadr_front: sample accumulator
// Sums samples into batches and pushes the closed batch (sum, count) into
// the queue on the sample that completes it.
// ----------------------------------------------------------------------------
module aadr_front
   import aadr_pkg::*;
#(
   parameter int MAX_SAMPLES = AADR_MAX_SAMPLES,
   parameter int SUM_W       = 16,
   parameter int CNT_W       = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  aadr_cfg_type        cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                q_full,
   output logic                push,
   output logic [SUM_W-1:0]    push_sum,
   output logic [CNT_W-1:0]    push_count
);

   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_SAMPLES);

   logic [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_add;
   logic [CMP_W-1:0] len_ext;
   logic [CNT_W-1:0] batch_len;
   logic             accept;
   logic             close;

   assign len_ext = CMP_W'(cfg.samples_per_reading);

   // zero length acts as one, long lengths clamp to the maximum
   always_comb begin
      if (len_ext == '0) begin
         batch_len = CNT_W'(1);
      end else if (len_ext > MAX_EXT) begin
         batch_len = CNT_W'(MAX_SAMPLES);
      end else begin
         batch_len = CNT_W'(len_ext);
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign sum_add   = sum_ff + SUM_W'(req_sample);
   assign cnt_add   = cnt_ff + 1'b1;
   assign close     = cnt_add >= batch_len;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         sum_in = close ? '0 : sum_add;
         cnt_in = close ? '0 : cnt_add;
      end
   end

   assign push       = accept && close;
   assign push_sum   = sum_add;
   assign push_count = cnt_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hw/rtl/aadr_queue.sv */
// ----------------------------------------------------------------------------
// aadr_queue: two-entry batch queue
// Holds closed batches between the accumulator and the compute engine.
// ----------------------------------------------------------------------------
module aadr_queue
   import aadr_pkg::*;
#(
   parameter int WIDTH = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/aadr_back.sv */
// ----------------------------------------------------------------------------
// aadr_back: batch compute engine
// Pops a batch, forms the products, runs up to three divisions on the shared
// divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module aadr_back
   import aadr_pkg::*;
#(
   parameter int SUM_W = 16,
   parameter int CNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aadr_cfg_type         cfg,
   input  logic                 q_empty,
   input  logic [SUM_W-1:0]     q_sum,
   input  logic [CNT_W-1:0]     q_count,
   output aadr_back_status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [AVG_W-1:0]     rsp_average_q6,
   output logic [MV_W-1:0]      rsp_millivolts,
   output logic [RES_W-1:0]     rsp_resistance_ohms,
   output logic                 rsp_infinite
);

   localparam int NUM_W = KNOWN_W + SUM_W;
   localparam int QX_W  = (NUM_W > RES_W) ? NUM_W : RES_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_AVG  = 3'd2;
   localparam logic [2:0] ST_MV   = 3'd3;
   localparam logic [2:0] ST_RES  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]       st_ff, st_in;
   logic [SUM_W-1:0] s_ff, s_in;
   logic [SUM_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] full_ff, full_in;
   logic [SUM_W-1:0] diff_ff, diff_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] mvn_ff, mvn_in;
   logic [AVG_W-1:0] avg_ff, avg_in;
   logic [MV_W-1:0]  mv_ff, mv_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic             inf_ff, inf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [MV_W-1:0]  rsp_mv_ff, rsp_mv_in;
   logic [RES_W-1:0] rsp_res_ff, rsp_res_in;
   logic             rsp_inf_ff, rsp_inf_in;

   logic [SUM_W-1:0] q_cnt_ext;
   logic [SUM_W-1:0] den;
   logic             den_zero;
   logic             div_start;
   logic [NUM_W-1:0] div_dividend;
   logic [SUM_W-1:0] div_divisor;
   logic             div_done;
   logic [NUM_W-1:0] div_quotient;
   logic [QX_W-1:0]  quo_ext;
   logic             load;

   assign q_cnt_ext = SUM_W'(q_count);
   assign den       = cfg.pull_up_mode ? s_ff : diff_ff;
   assign den_zero  = den == '0;
   assign quo_ext   = QX_W'(div_quotient);
   assign load      = (st_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   aadr_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // one operand pair per division phase
   always_comb begin
      div_start    = 1'b0;
      div_dividend = NUM_W'(s_ff) << 6;
      div_divisor  = cnt_ff;
      case (st_ff)
         ST_MUL: begin
            div_start = 1'b1;
         end
         ST_AVG: begin
            div_start    = div_done;
            div_dividend = mvn_ff;
            div_divisor  = full_ff;
         end
         ST_MV: begin
            div_start    = div_done && !den_zero;
            div_dividend = num_ff;
            div_divisor  = den;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      st_in   = st_ff;
      s_in    = s_ff;
      cnt_in  = cnt_ff;
      full_in = full_ff;
      diff_in = diff_ff;
      num_in  = num_ff;
      mvn_in  = mvn_ff;
      avg_in  = avg_ff;
      mv_in   = mv_ff;
      res_in  = res_ff;
      inf_in  = inf_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               s_in    = q_sum;
               cnt_in  = q_cnt_ext;
               // full scale is 1023 times the count
               full_in = (q_cnt_ext << 10) - q_cnt_ext;
               diff_in = ((q_cnt_ext << 10) - q_cnt_ext) - q_sum;
               st_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            num_in = NUM_W'(cfg.known_ohms) * NUM_W'(cfg.pull_up_mode ? diff_ff : s_ff);
            mvn_in = NUM_W'(cfg.ref_millivolts) * NUM_W'(s_ff);
            st_in  = ST_AVG;
         end
         ST_AVG: begin
            if (div_done) begin
               avg_in = div_quotient[AVG_W-1:0];
               st_in  = ST_MV;
            end
         end
         ST_MV: begin
            if (div_done) begin
               mv_in = div_quotient[MV_W-1:0];
               if (den_zero) begin
                  res_in = '1;
                  inf_in = 1'b1;
                  st_in  = ST_OUT;
               end else begin
                  st_in = ST_RES;
               end
            end
         end
         ST_RES: begin
            if (div_done) begin
               // saturate a quotient that does not fit in 32 bits
               if (|quo_ext[QX_W-1:RES_W]) begin
                  res_in = '1;
                  inf_in = 1'b1;
               end else begin
                  res_in = quo_ext[RES_W-1:0];
                  inf_in = 1'b0;
               end
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_inf_in   = rsp_inf_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = avg_ff;
         rsp_mv_in    = mv_ff;
         rsp_res_in   = res_ff;
         rsp_inf_in   = inf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff       <= s_in;
      cnt_ff     <= cnt_in;
      full_ff    <= full_in;
      diff_ff    <= diff_in;
      num_ff     <= num_in;
      mvn_ff     <= mvn_in;
      avg_ff     <= avg_in;
      mv_ff      <= mv_in;
      res_ff     <= res_in;
      inf_ff     <= inf_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_mv_ff  <= rsp_mv_in;
      rsp_res_ff <= rsp_res_in;
      rsp_inf_ff <= rsp_inf_in;
   end

   assign status.busy = st_ff != ST_IDLE;
   assign status.pop  = (st_ff == ST_IDLE) && !q_empty;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average_q6      = rsp_avg_ff;
   assign rsp_millivolts      = rsp_mv_ff;
   assign rsp_resistance_ohms = rsp_res_ff;
   assign rsp_infinite        = rsp_inf_ff;

endmodule

/* hw/rtl/adc_average_divider_resistance.sv */
// ----------------------------------------------------------------------------
// adc_average_divider_resistance: divider resistance from averaged samples
// Sums converter samples in batches and reports average, millivolts and the
// unknown divider resistance once per batch.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_sample
//   rsp     | out       | rsp_valid/rsp_ready  | average_q6, millivolts,
//           |           |                      | resistance_ohms, infinite
//   csr     | in        | csr_write_enable     | csr_index, csr_data
//
// A sample is taken on any valid/ready beat; a batch-closing sample hands the
// batch to a two-entry queue. The compute engine takes one batch at a time and
// runs three divisions per batch, two on a zero denominator, on the
// one-bit-per-cycle divider with a dividend of NUM_W = 20 + sum width bits.
// req_ready drops only while both queue entries hold closed batches.
// Synchronous reset clears the batch, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module adc_average_divider_resistance
   import aadr_pkg::*;
#(
   parameter int MAX_SAMPLES = AADR_MAX_SAMPLES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [AVG_W-1:0]       rsp_average_q6,
   output logic [MV_W-1:0]        rsp_millivolts,
   output logic [RES_W-1:0]       rsp_resistance_ohms,
   output logic                   rsp_infinite,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SUM_W = $clog2(MAX_SAMPLES * FULL_CODE + 1);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   aadr_cfg_type         cfg_ff, cfg_in;
   aadr_back_status_type back_status;
   logic                 push;
   logic [SUM_W-1:0]     push_sum;
   logic [CNT_W-1:0]     push_count;
   logic [SUM_W+CNT_W-1:0] pop_data;
   logic                 q_full;
   logic                 q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PULL_UP:    cfg_in.pull_up_mode        = csr_data[0];
            CSR_REF_MV:     cfg_in.ref_millivolts      = csr_data[MV_W-1:0];
            CSR_KNOWN_OHMS: cfg_in.known_ohms          = csr_data[KNOWN_W-1:0];
            CSR_SAMPLES:    cfg_in.samples_per_reading = csr_data[LEN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pull_up_mode        <= 1'b0;
         cfg_ff.ref_millivolts      <= RST_REF_MV;
         cfg_ff.known_ohms          <= RST_KNOWN_OHMS;
         cfg_ff.samples_per_reading <= RST_SAMPLES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aadr_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_full     (q_full),
      .push       (push),
      .push_sum   (push_sum),
      .push_count (push_count)
   );

   aadr_queue #(
      .WIDTH (SUM_W + CNT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_sum, push_count}),
      .pop       (back_status.pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   aadr_back #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_empty             (q_empty),
      .q_sum               (pop_data[SUM_W+CNT_W-1:CNT_W]),
      .q_count             (pop_data[CNT_W-1:0]),
      .status              (back_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_average_q6      (rsp_average_q6),
      .rsp_millivolts      (rsp_millivolts),
      .rsp_resistance_ohms (rsp_resistance_ohms),
      .rsp_infinite        (rsp_infinite)
   );

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && q_empty)
      else $error("result or queue not cleared by reset");

   a_result_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_status.busy))
      else $error("result raised without the engine working on a batch");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> !q_empty)
      else $error("batch popped from an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("batch pushed into a full queue");

endmodule

/* tb/sv/tb_adc_average_divider_resistance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_average_divider_resistance: batch average and divider resistance
// Drives converter samples through valid/ready with bursty traffic and a
// stalling receiver, keeps a shadow of the batch sum, count and registers,
// and checks every reading field by field against its own prediction.
// ----------------------------------------------------------------------------
module tb_adc_average_divider_resistance;
   import aadr_pkg::*;

   localparam int SETTLE_CYCLES = 200;
   localparam int TARGET_ITEMS  = 770;

   typedef struct packed {
      logic [AVG_W-1:0] average_q6;
      logic [MV_W-1:0]  millivolts;
      logic [RES_W-1:0] resistance_ohms;
      logic             infinite;
   } reading_type;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_COMB, STALL_LONG} stall_mode_type;
   typedef enum int {
      STYLE_UNIFORM, STYLE_ALL_FULL, STYLE_ALL_ZERO, STYLE_NEAR_FULL, STYLE_NEAR_ZERO
   } sample_style_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [AVG_W-1:0]       rsp_average_q6;
   logic [MV_W-1:0]        rsp_millivolts;
   logic [RES_W-1:0]       rsp_resistance_ohms;
   logic                   rsp_infinite;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   adc_average_divider_resistance DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_average_q6     (rsp_average_q6),
      .rsp_millivolts     (rsp_millivolts),
      .rsp_resistance_ohms(rsp_resistance_ohms),
      .rsp_infinite       (rsp_infinite),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // shadow of the block
   aadr_cfg_type    cfg_shadow;
   logic [15:0]     batch_sum;
   logic [LEN_W-1:0] batch_count;
   reading_type     pending_readings[$];

   int mismatch_count;
   int samples_sent;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic reading_type predict_reading(input logic [15:0] sum,
                                                   input logic [LEN_W-1:0] count,
                                                   input aadr_cfg_type cfg);
      longint unsigned s, n, full, num, den, quo;
      reading_type r;
      s    = sum;
      n    = count;
      full = 64'(FULL_CODE) * n;
      r.average_q6 = AVG_W'((s << 6) / n);
      r.millivolts = MV_W'((64'(cfg.ref_millivolts) * s) / full);
      if (cfg.pull_up_mode) begin
         num = 64'(cfg.known_ohms) * (full - s);
         den = s;
      end else begin
         num = 64'(cfg.known_ohms) * s;
         den = full - s;
      end
      r.infinite = 1'b0;
      if (den == 0) begin
         r.infinite        = 1'b1;
         r.resistance_ohms = '1;
      end else begin
         quo = num / den;
         if (quo > 64'hFFFF_FFFF) begin
            r.infinite        = 1'b1;
            r.resistance_ohms = '1;
         end else begin
            r.resistance_ohms = RES_W'(quo);
         end
      end
      return r;
   endfunction

   // fold one accepted sample into the shadow batch
   task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value);
      int len;
      len = cfg_shadow.samples_per_reading;
      if (len == 0) len = 1;
      if (len > AADR_MAX_SAMPLES) len = AADR_MAX_SAMPLES;
      batch_sum   = batch_sum + 16'(value);
      batch_count = batch_count + 1'b1;
      if (batch_count >= len) begin
         pending_readings.push_back(predict_reading(batch_sum, batch_count, cfg_shadow));
         batch_sum   = '0;
         batch_count = '0;
      end
   endtask

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      accumulate_sample(value);
      samples_sent++;
      @(negedge clock);
   endtask

   // drop valid, wait for every reading, then let the engine drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_PULL_UP:    cfg_shadow.pull_up_mode        = value[0];
         CSR_REF_MV:     cfg_shadow.ref_millivolts      = value[MV_W-1:0];
         CSR_KNOWN_OHMS: cfg_shadow.known_ohms          = value[KNOWN_W-1:0];
         CSR_SAMPLES:    cfg_shadow.samples_per_reading = value[LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(input logic pull_up, input logic [MV_W-1:0] ref_mv,
                            input logic [KNOWN_W-1:0] ohms, input logic [LEN_W-1:0] len);
      write_reg(CSR_PULL_UP, CSR_DATA_W'(pull_up));
      write_reg(CSR_REF_MV, CSR_DATA_W'(ref_mv));
      write_reg(CSR_KNOWN_OHMS, CSR_DATA_W'(ohms));
      write_reg(CSR_SAMPLES, CSR_DATA_W'(len));
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_style_type style);
      case (style)
         STYLE_ALL_FULL:  return SAMPLE_W'(FULL_CODE);
         STYLE_ALL_ZERO:  return '0;
         STYLE_NEAR_FULL: return SAMPLE_W'($urandom_range(1019, 1023));
         STYLE_NEAR_ZERO: return SAMPLE_W'($urandom_range(0, 4));
         default:         return SAMPLE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic send_batch(input int len, input sample_style_type style);
      for (int i = 0; i < len; i++) send_sample(pick_sample(style));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_config();
      send_batch(50, STYLE_UNIFORM);
   endtask

   task automatic test_sample_extremes();
      settle();
      configure(1'b0, 13'h1FFF, 20'd10000, 7'd1);
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd512);
      send_sample(10'h155);
      send_sample(10'h2AA);
   endtask

   task automatic test_pull_up();
      settle();
      configure(1'b1, 13'd0, 20'd4700, 7'd1);
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd1);
   endtask

   // zero length acts as one; zero resistor still flags a zero denominator
   task automatic test_zero_length_zero_ohms();
      settle();
      configure(1'b0, 13'd5000, 20'd0, 7'd0);
      send_sample(10'd500);
      send_sample(10'd1023);
   endtask

   task automatic test_overflow();
      settle();
      configure(1'b0, 13'd3300, 20'hFFFFF, 7'd5);
      repeat (4) send_sample(10'd1023);
      send_sample(10'd1022);
      settle();
      write_reg(CSR_PULL_UP, CSR_DATA_W'(1));
      repeat (4) send_sample(10'd0);
      send_sample(10'd1);
   endtask

   task automatic test_length_lowered();
      settle();
      configure(1'b0, 13'd3300, 20'd10000, 7'd50);
      repeat (3) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
      settle();
      write_reg(CSR_SAMPLES, CSR_DATA_W'(2));
      send_sample(SAMPLE_W'($urandom_range(0, 1023)));
   endtask

   // length above the maximum acts as the maximum
   task automatic test_long_length();
      settle();
      configure(1'b0, 13'd3300, 20'(1000000), 7'd127);
      send_batch(AADR_MAX_SAMPLES, STYLE_NEAR_FULL);
      settle();
      configure(1'b1, 13'd4096, 20'hFFFFF, 7'd64);
      send_batch(AADR_MAX_SAMPLES, STYLE_NEAR_ZERO);
   endtask

   task automatic test_random_batches();
      int r, len, batches;
      logic pull;
      logic [MV_W-1:0] ref_mv;
      logic [KNOWN_W-1:0] ohms;
      sample_style_type style;
      while (samples_sent < TARGET_ITEMS) begin
         settle();
         pull = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 10)      ref_mv = '0;
         else if (r < 20) ref_mv = '1;
         else if (r < 40) ref_mv = 13'd5000;
         else             ref_mv = MV_W'($urandom_range(0, 8191));
         r = $urandom_range(0, 99);
         if (r < 8)       ohms = '0;
         else if (r < 25) ohms = '1;
         else if (r < 50) ohms = KNOWN_W'($urandom_range(1, 100));
         else             ohms = KNOWN_W'($urandom_range(0, 20'hFFFFF));
         r = $urandom_range(0, 99);
         if (r < 60)      len = $urandom_range(1, 8);
         else if (r < 85) len = $urandom_range(9, 32);
         else if (r < 94) len = $urandom_range(33, 64);
         else if (r < 97) len = 0;
         else             len = $urandom_range(65, 127);
         configure(pull, ref_mv, ohms, LEN_W'(len));
         if (len == 0) len = 1;
         if (len > AADR_MAX_SAMPLES) len = AADR_MAX_SAMPLES;
         batches = (len > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
         for (int b = 0; b < batches; b++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      style = STYLE_UNIFORM;
            else if (r < 65) style = STYLE_ALL_FULL;
            else if (r < 75) style = STYLE_ALL_ZERO;
            else if (r < 88) style = STYLE_NEAR_FULL;
            else             style = STYLE_NEAR_ZERO;
            send_batch(len, style);
         end
         // leave a partial batch open now and then for the next setting
         if ($urandom_range(0, 3) == 0)
            send_batch($urandom_range(1, 3), STYLE_UNIFORM);
      end
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin : receiver_stall
      stall_mode_type mode;
      int mode_left, hold, tick;
      logic ready_val;
      mode      = STALL_NONE;
      mode_left = 0;
      hold      = 0;
      tick      = 0;
      ready_val = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         tick++;
         case (mode)
            STALL_NONE: ready_val = 1'b1;
            STALL_COIN: ready_val = 1'($urandom_range(0, 1));
            STALL_COMB: ready_val = (tick % 7) < 3;
            default: begin
               if (hold == 0) begin
                  ready_val = ~ready_val;
                  hold = ready_val ? $urandom_range(1, 4) : $urandom_range(5, 40);
               end
               hold--;
            end
         endcase
         rsp_ready <= ready_val;
      end
   end

   // ---------------------------------------------------------------- checker

   reading_type got_reading, want_reading;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_reading = {rsp_average_q6, rsp_millivolts, rsp_resistance_ohms, rsp_infinite};
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: average_q6 %0d millivolts %0d resistance_ohms %0d",
                   rsp_average_q6, rsp_millivolts, rsp_resistance_ohms);
            mismatch_count++;
         end else begin
            want_reading = pending_readings.pop_front();
            if (got_reading.average_q6 !== want_reading.average_q6) begin
               $error("average_q6: expected %0d, actual %0d",
                      want_reading.average_q6, got_reading.average_q6);
               mismatch_count++;
            end
            if (got_reading.millivolts !== want_reading.millivolts) begin
               $error("millivolts: expected %0d, actual %0d",
                      want_reading.millivolts, got_reading.millivolts);
               mismatch_count++;
            end
            if (got_reading.resistance_ohms !== want_reading.resistance_ohms) begin
               $error("resistance_ohms: expected %0d, actual %0d",
                      want_reading.resistance_ohms, got_reading.resistance_ohms);
               mismatch_count++;
            end
            if (got_reading.infinite !== want_reading.infinite) begin
               $error("infinite: expected %0d, actual %0d",
                      want_reading.infinite, got_reading.infinite);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PULL_UP;
      csr_data         = '0;
      mismatch_count   = 0;
      samples_sent     = 0;
      burst_left       = 0;
      batch_sum        = '0;
      batch_count      = '0;
      cfg_shadow.pull_up_mode        = 1'b0;
      cfg_shadow.ref_millivolts      = RST_REF_MV;
      cfg_shadow.known_ohms          = RST_KNOWN_OHMS;
      cfg_shadow.samples_per_reading = RST_SAMPLES;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_config();
      test_sample_extremes();
      test_pull_up();
      test_zero_length_zero_ohms();
      test_overflow();
      test_length_lowered();
      test_long_length();
      test_random_batches();

      settle();
      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* adc_average_divider_resistance.f */
hw/rtl/aadr_pkg.sv
hw/rtl/aadr_div.sv
hw/rtl/aadr_front.sv
hw/rtl/aadr_queue.sv
hw/rtl/aadr_back.sv
hw/rtl/adc_average_divider_resistance.sv
tb/sv/tb_adc_average_divider_resistance.sv
